>>> rtl/core/ksrs_pkg.sv
// Types and constants shared by the keyframe rate sequencer and its channel interfaces.
package ksrs_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DIVIDER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE      = 1'b1;

    localparam logic [2:0] CMD_WRITE_KEY   = 3'd0;
    localparam logic [2:0] CMD_SELECT_SLOT = 3'd1;
    localparam logic [2:0] CMD_START       = 3'd2;
    localparam logic [2:0] CMD_TICK        = 3'd3;
    localparam logic [2:0] CMD_STEP        = 3'd4;

    localparam logic [1:0] AXIS_DIST = 2'd0;
    localparam logic [1:0] AXIS_PAN  = 2'd1;
    localparam logic [1:0] AXIS_TILT = 2'd2;

    localparam logic [7:0]  DIVIDER_RESET = 8'd61;
    localparam logic [15:0] RATE_RESET    = 16'd15625;
    localparam logic [15:0] STOP_PERIOD   = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  slot;
        logic [15:0] key_distance;
        logic [15:0] key_pan;
        logic [15:0] key_tilt;
        logic [15:0] key_time;
        logic [1:0]  axis;
    } t_cmd_item;

    typedef struct packed {
        logic        run_active;
        logic        segment_changed;
        logic [15:0] dist_period;
        logic [15:0] pan_period;
        logic [15:0] tilt_period;
        logic        dist_forward;
        logic        dist_enabled;
        logic [3:0]  active_key;
        logic [15:0] elapsed_seconds;
        logic [15:0] dist_position;
        logic [15:0] pan_position;
        logic [15:0] tilt_position;
    } t_stat_item;

    typedef struct packed {
        logic [15:0] distance;
        logic [15:0] pan;
        logic [15:0] tilt;
        logic [15:0] stamp;
    } t_keyframe;

endpackage

>>> rtl/core/ksrs_cmd_if.sv
// Command channel: valid/ready handshake carrying one command item.
interface ksrs_cmd_if;
    logic                valid;
    logic                ready;
    ksrs_pkg::t_cmd_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/ksrs_stat_if.sv
// Status channel: valid/ready handshake carrying one status item.
interface ksrs_stat_if;
    logic                 valid;
    logic                 ready;
    ksrs_pkg::t_stat_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/keyframe_stepper_rate_sequencer_core.sv
// Keyframe rate sequencer for three stepper axes (distance, pan, tilt).
//
// Usage: commands enter on i_cmd_if (valid/ready); every accepted command yields
// exactly one status transaction on o_stat_if. The block handles one command at
// a time: i_cmd_if.ready is high only while idle, and the status stays on
// o_stat_if until the receiver takes it; a stalled receiver holds the block.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_wdata; the user must
// write them only while idle, which the block itself does not enforce.
// Steps from accept to status valid:
//   write key, select slot, step, plain tick, unused codes: straight to status
//   tick that ends a second without reaching the keyframe: read, check
//   start: read, then evaluate (and divide for) the distance axis only
//   tick that moves to the next keyframe: read, check, read, divide each axis
// The long cases run one restoring divider (one quotient bit per cycle) shared by
// all axes: distance / span, then rate / quotient. Idle follows the handshake.
// Reset (synchronous, active low) clears the keyframe table through per-entry
// valid bits, zeroes positions and timers, sets all directions forward and all
// periods to 15625, and restores the register defaults (61, 15625).
module keyframe_stepper_rate_sequencer_core #(
    parameter int KEY_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ksrs_cmd_if.sink                            i_cmd_if,
    ksrs_stat_if.source                         o_stat_if,
    input  logic                                i_cfg_we,
    input  logic [ksrs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ksrs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    // Only slots 0..15 are addressable by the write slot register.
    localparam int STORE_DEPTH = (KEY_DEPTH < 16) ? KEY_DEPTH : 16;
    localparam int AW          = $clog2(KEY_DEPTH);
    localparam int SW          = $clog2(STORE_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_DIV_Q = 3'd3;
    localparam logic [2:0] S_DIV_P = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam logic [1:0] MODE_CHECK = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_ADV   = 2'd2;

    logic [2:0]    r_state, n_state;
    logic [1:0]    r_mode;
    logic [1:0]    r_axis;
    logic [7:0]    r_second_div;
    logic [15:0]   r_rate;
    logic [3:0]    r_write_slot;
    logic [AW-1:0] r_active;
    logic          r_started;
    logic [7:0]    r_tick;
    logic [15:0]   r_seconds;
    logic [15:0]   r_pos    [3];
    logic          r_dir    [3];
    logic [15:0]   r_period [3];
    logic          r_dist_run;
    logic          r_changed;
    logic          r_valid  [STORE_DEPTH];

    ksrs_pkg::t_keyframe r_mem [STORE_DEPTH];
    ksrs_pkg::t_keyframe r_kf;
    logic                r_kf_ok;

    logic [15:0] r_rem;
    logic [15:0] r_quo;
    logic [15:0] r_den;
    logic [3:0]  r_cnt;

    logic                w_accept;
    ksrs_pkg::t_cmd_item w_cmd;
    logic                w_slot_ok;
    logic [SW-1:0]       w_rd_addr;
    logic                w_rd_ok;
    ksrs_pkg::t_keyframe w_kf;
    logic [AW-1:0]       w_active_nx;
    logic                w_due;
    logic [16:0]         w_span;
    logic                w_span_ok;
    logic [15:0]         w_tgt;
    logic [15:0]         w_pos;
    logic [15:0]         w_delta;
    logic [16:0]         w_shift;
    logic                w_ge;
    logic [15:0]         w_rem_nx;
    logic [15:0]         w_quo_nx;
    logic                w_last;
    logic                w_fin;
    logic [15:0]         w_fin_period;
    logic [AW+3:0]       w_active_ext;

    assign w_cmd    = i_cmd_if.data;
    assign w_accept = i_cmd_if.valid && i_cmd_if.ready;
    assign i_cmd_if.ready = (r_state == S_IDLE);

    assign w_slot_ok = ({1'b0, r_write_slot} < 5'(STORE_DEPTH));
    assign w_rd_addr = r_active[SW-1:0];
    assign w_rd_ok   = ({1'b0, r_active} < (AW+1)'(STORE_DEPTH)) && r_valid[w_rd_addr];
    assign w_kf      = r_kf_ok ? r_kf : '0;

    assign w_active_nx = (r_active == AW'(KEY_DEPTH - 1)) ? '0 : r_active + 1'b1;
    assign w_due       = (r_seconds >= w_kf.stamp);

    // signed span = stamp - seconds; nonpositive stops the axis
    assign w_span    = {1'b0, w_kf.stamp} - {1'b0, r_seconds};
    assign w_span_ok = !w_span[16] && (w_span[15:0] != 16'd0);

    always_comb begin
        case (r_axis)
            ksrs_pkg::AXIS_DIST: begin
                w_tgt = w_kf.distance;
                w_pos = r_pos[0];
            end
            ksrs_pkg::AXIS_PAN: begin
                w_tgt = w_kf.pan;
                w_pos = r_pos[1];
            end
            default: begin
                w_tgt = w_kf.tilt;
                w_pos = r_pos[2];
            end
        endcase
    end

    assign w_delta = (w_tgt >= w_pos) ? (w_tgt - w_pos) : (w_pos - w_tgt);

    // restoring divider step: one quotient bit per cycle
    assign w_shift  = {r_rem, r_quo[15]};
    assign w_ge     = (w_shift >= {1'b0, r_den});
    assign w_rem_nx = w_ge ? 16'(w_shift - {1'b0, r_den}) : w_shift[15:0];
    assign w_quo_nx = {r_quo[14:0], w_ge};

    assign w_last = (r_mode == MODE_START) || (r_axis == ksrs_pkg::AXIS_TILT);

    always_comb begin
        w_fin        = 1'b0;
        w_fin_period = ksrs_pkg::STOP_PERIOD;
        case (r_state)
            S_EVAL: begin
                if (r_mode != MODE_CHECK && !w_span_ok) begin
                    w_fin = 1'b1;
                end
            end
            S_DIV_Q: begin
                if (r_cnt == 4'd0 && w_quo_nx == 16'd0) begin
                    w_fin = 1'b1;
                end
            end
            S_DIV_P: begin
                if (r_cnt == 4'd0) begin
                    w_fin        = 1'b1;
                    w_fin_period = w_quo_nx;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_cmd.command)
                        ksrs_pkg::CMD_START: n_state = S_RD;
                        ksrs_pkg::CMD_TICK: begin
                            if (r_tick == r_second_div && r_started) begin
                                n_state = S_RD;
                            end else begin
                                n_state = S_OUT;
                            end
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_RD: n_state = S_EVAL;
            S_EVAL: begin
                if (r_mode == MODE_CHECK) begin
                    n_state = w_due ? S_RD : S_OUT;
                end else if (!w_span_ok) begin
                    n_state = w_last ? S_OUT : S_EVAL;
                end else begin
                    n_state = S_DIV_Q;
                end
            end
            S_DIV_Q: begin
                if (r_cnt == 4'd0) begin
                    if (w_quo_nx == 16'd0) begin
                        n_state = w_last ? S_OUT : S_EVAL;
                    end else begin
                        n_state = S_DIV_P;
                    end
                end
            end
            S_DIV_P: begin
                if (r_cnt == 4'd0) begin
                    n_state = w_last ? S_OUT : S_EVAL;
                end
            end
            S_OUT: begin
                if (o_stat_if.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= MODE_CHECK;
            r_axis       <= ksrs_pkg::AXIS_DIST;
            r_second_div <= ksrs_pkg::DIVIDER_RESET;
            r_rate       <= ksrs_pkg::RATE_RESET;
            r_write_slot <= '0;
            r_active     <= '0;
            r_started    <= 1'b0;
            r_tick       <= '0;
            r_seconds    <= '0;
            r_dist_run   <= 1'b0;
            r_changed    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_pos[i]    <= '0;
                r_dir[i]    <= 1'b1;
                r_period[i] <= ksrs_pkg::RATE_RESET;
            end
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ksrs_pkg::CFG_SECOND_DIVIDER: r_second_div <= i_cfg_wdata[7:0];
                    ksrs_pkg::CFG_STEP_RATE:      r_rate       <= i_cfg_wdata;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_changed <= 1'b0;
                        case (w_cmd.command)
                            ksrs_pkg::CMD_WRITE_KEY: begin
                                if (w_slot_ok) begin
                                    r_valid[r_write_slot[SW-1:0]] <= 1'b1;
                                end
                            end
                            ksrs_pkg::CMD_SELECT_SLOT: r_write_slot <= w_cmd.slot;
                            ksrs_pkg::CMD_START: begin
                                r_started <= 1'b1;
                                r_mode    <= MODE_START;
                                r_axis    <= ksrs_pkg::AXIS_DIST;
                            end
                            ksrs_pkg::CMD_TICK: begin
                                r_mode <= MODE_CHECK;
                                if (r_tick != r_second_div) begin
                                    r_tick <= r_tick + 8'd1;
                                end else begin
                                    r_tick <= '0;
                                    if (r_started) begin
                                        r_seconds <= r_seconds + 16'd1;
                                    end
                                end
                            end
                            ksrs_pkg::CMD_STEP: begin
                                case (w_cmd.axis)
                                    ksrs_pkg::AXIS_DIST: begin
                                        if (r_dist_run) begin
                                            r_pos[0] <= r_dir[0] ? r_pos[0] + 16'd1
                                                                 : r_pos[0] - 16'd1;
                                        end
                                    end
                                    ksrs_pkg::AXIS_PAN: begin
                                        r_pos[1] <= r_dir[1] ? r_pos[1] + 16'd1
                                                             : r_pos[1] - 16'd1;
                                    end
                                    ksrs_pkg::AXIS_TILT: begin
                                        r_pos[2] <= r_dir[2] ? r_pos[2] + 16'd1
                                                             : r_pos[2] - 16'd1;
                                    end
                                    default: ;
                                endcase
                            end
                            default: ;
                        endcase
                    end
                end
                S_EVAL: begin
                    if (r_mode == MODE_CHECK && w_due) begin
                        r_active  <= w_active_nx;
                        r_changed <= 1'b1;
                        r_mode    <= MODE_ADV;
                        r_axis    <= ksrs_pkg::AXIS_DIST;
                    end
                end
                default: ;
            endcase

            if (w_fin) begin
                r_period[r_axis] <= w_fin_period;
                if (r_mode == MODE_ADV && w_fin_period != ksrs_pkg::STOP_PERIOD) begin
                    r_dir[r_axis] <= !(w_tgt < w_pos);
                end
                if (r_axis == ksrs_pkg::AXIS_DIST) begin
                    r_dist_run <= (w_fin_period != ksrs_pkg::STOP_PERIOD);
                end
                if (!w_last) begin
                    r_axis <= r_axis + 2'd1;
                end
            end
        end
    end

    // keyframe table
    always_ff @(posedge i_clk) begin
        if (w_accept && w_cmd.command == ksrs_pkg::CMD_WRITE_KEY && w_slot_ok) begin
            r_mem[r_write_slot[SW-1:0]] <= '{distance: w_cmd.key_distance,
                                              pan:      w_cmd.key_pan,
                                              tilt:     w_cmd.key_tilt,
                                              stamp:    w_cmd.key_time};
        end
        if (r_state == S_RD) begin
            r_kf    <= r_mem[w_rd_addr];
            r_kf_ok <= w_rd_ok;
        end
    end

    // shared divider datapath: distance / span, then rate / quotient
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_EVAL: begin
                r_rem <= '0;
                r_quo <= w_delta;
                r_den <= w_span[15:0];
                r_cnt <= 4'd15;
            end
            S_DIV_Q: begin
                if (r_cnt != 4'd0) begin
                    r_rem <= w_rem_nx;
                    r_quo <= w_quo_nx;
                    r_cnt <= r_cnt - 4'd1;
                end else begin
                    r_rem <= '0;
                    r_quo <= r_rate;
                    r_den <= w_quo_nx;
                    r_cnt <= 4'd15;
                end
            end
            S_DIV_P: begin
                r_rem <= w_rem_nx;
                r_quo <= w_quo_nx;
                r_cnt <= r_cnt - 4'd1;
            end
            default: ;
        endcase
    end

    assign w_active_ext = {4'b0, r_active};

    assign o_stat_if.valid                = (r_state == S_OUT);
    assign o_stat_if.data.run_active      = r_started;
    assign o_stat_if.data.segment_changed = r_changed;
    assign o_stat_if.data.dist_period     = r_period[0];
    assign o_stat_if.data.pan_period      = r_period[1];
    assign o_stat_if.data.tilt_period     = r_period[2];
    assign o_stat_if.data.dist_forward    = r_dir[0];
    assign o_stat_if.data.dist_enabled    = r_dist_run;
    assign o_stat_if.data.active_key      = w_active_ext[3:0];
    assign o_stat_if.data.elapsed_seconds = r_seconds;
    assign o_stat_if.data.dist_position   = r_pos[0];
    assign o_stat_if.data.pan_position    = r_pos[1];
    assign o_stat_if.data.tilt_position   = r_pos[2];

    a_busy_while_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat_if.valid |-> !i_cmd_if.ready)
        else $error("command taken while status pending");

    a_run_matches_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dist_run |-> (r_period[0] != ksrs_pkg::STOP_PERIOD))
        else $error("distance axis running with stop period");

    a_active_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_active} < (AW+1)'(KEY_DEPTH))
        else $error("active keyframe index out of range");

    a_rate_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_P || r_state == S_DIV_Q) |-> (r_den != 16'd0))
        else $error("divider running with zero divisor");

    a_change_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat_if.valid && r_changed) |-> r_started)
        else $error("segment change reported before start");

endmodule
